/* hdl/gdw_pkg.sv */
// Shared types and constants for the Gregorian weekday block.
// Used by every module under hdl; depends on nothing.
package gdw_pkg;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_MONTH = 2'd1;
    localparam logic [1:0] STATUS_BAD_DAY   = 2'd2;

    localparam logic [15:0] YEAR_BIAS = 16'd400;

    // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for x below 2**17
    localparam int          DIV100_SHIFT = 24;
    localparam logic [17:0] DIV100_MUL   = 18'd167773;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [5:0]  day_of_month;
    } date_t;

    typedef struct packed {
        logic [2:0] weekday;
        logic [1:0] status;
    } result_t;

    // Classified transaction passed from the front end to the back end.
    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] span;
        logic [5:0]  base;
    } work_t;

endpackage

/* hdl/gregorian_weekday_with_check.sv */
// Gregorian weekday with date check: top level.
// Path: a date is queued, then held in the three back-end stages p, s and o.
// Throughput: one transaction per cycle unless an unpopped result stalls it.
// Reset: rst_n clears the queue and pipeline valid bits; no results pending.
// Depends on gdw_pkg, gdw_front, gdw_queue, gdw_back.
module gregorian_weekday_with_check #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  gdw_pkg::date_t   date,
    output logic             empty,
    input  logic             pop,
    output gdw_pkg::result_t result
);
    import gdw_pkg::*;

    work_t front_work;
    work_t queue_work;
    logic  queue_valid;
    logic  back_take;

    gdw_front u_front (
        .date (date),
        .work (front_work)
    );

    gdw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_work),
        .full    (full),
        .rd_en   (back_take),
        .rd_data (queue_work),
        .valid   (queue_valid)
    );

    gdw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (queue_valid),
        .work       (queue_work),
        .take       (back_take),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

/* hdl/gdw_front.sv */
// Front end: checks month and day and prepares the day-count terms.
// Depends on gdw_pkg.
module gdw_front (
    input  gdw_pkg::date_t date,
    output gdw_pkg::work_t work
);
    import gdw_pkg::*;

    logic [15:0] year_m1;
    logic [33:0] prod_a;
    logic [33:0] prod_b;
    logic [9:0]  cent_a;
    logic [9:0]  cent_b;
    logic        div100;
    logic        div400;
    logic        leap;
    logic [5:0]  limit;
    logic [2:0]  offset;
    logic        early;

    assign year_m1 = date.year - 16'd1;
    assign prod_a  = {18'd0, date.year} * {16'd0, DIV100_MUL};
    assign prod_b  = {18'd0, year_m1} * {16'd0, DIV100_MUL};
    assign cent_a  = prod_a[33:DIV100_SHIFT];
    assign cent_b  = prod_b[33:DIV100_SHIFT];

    // A century boundary lies between year - 1 and year exactly when year % 100 == 0.
    assign div100 = (date.year == 16'd0) || (cent_a != cent_b);
    assign div400 = div100 && (cent_a[1:0] == 2'b00);
    assign leap   = ((date.year[1:0] == 2'b00) && !div100) || div400;

    always_comb
    begin
        case (date.month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: limit = 6'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                  limit = 6'd30;
            4'd2:                                      limit = leap ? 6'd29 : 6'd28;
            default:                                   limit = 6'd0;
        endcase
    end

    always_comb
    begin
        case (date.month)
            4'd2:    offset = 3'd3;
            4'd3:    offset = 3'd2;
            4'd4:    offset = 3'd5;
            4'd6:    offset = 3'd3;
            4'd7:    offset = 3'd5;
            4'd8:    offset = 3'd1;
            4'd9:    offset = 3'd4;
            4'd10:   offset = 3'd6;
            4'd11:   offset = 3'd2;
            4'd12:   offset = 3'd4;
            default: offset = 3'd0;
        endcase
    end

    assign early = (date.month < 4'd3);

    always_comb
    begin
        if (!(date.month inside {[4'd1:4'd12]}))
        begin
            work.status = STATUS_BAD_MONTH;
        end
        else if ((date.day_of_month == 6'd0) || (date.day_of_month > limit))
        begin
            work.status = STATUS_BAD_DAY;
        end
        else
        begin
            work.status = STATUS_OK;
        end
        work.span = {1'b0, date.year} + {1'b0, YEAR_BIAS} - {16'd0, early};
        work.base = {3'd0, offset} + date.day_of_month;
    end

endmodule

/* hdl/gdw_queue.sv */
// Short queue between the front end and the back end.
// Depends on gdw_pkg.
module gdw_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  gdw_pkg::work_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output gdw_pkg::work_t rd_data,
    output logic           valid
);
    import gdw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hdl/gdw_back.sv */
// Back end: day count and modulo-7 reduction in three pipeline stages.
// Depends on gdw_pkg.
module gdw_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             work_valid,
    input  gdw_pkg::work_t   work,
    output logic             take,
    output gdw_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);
    import gdw_pkg::*;

    logic        p_valid_reg;
    logic [1:0]  p_status_reg;
    logic [16:0] p_span_reg;
    logic [5:0]  p_base_reg;
    logic [10:0] p_cent_reg;
    logic [8:0]  p_quad_reg;

    logic        s_valid_reg;
    logic [1:0]  s_status_reg;
    logic [16:0] s_sum_reg;

    logic        o_valid_reg;
    result_t     o_result_reg;

    logic        o_adv;
    logic        s_adv;
    logic        p_adv;
    logic [34:0] cent_prod;
    logic [32:0] quad_prod;
    logic [16:0] sum_next;
    logic [5:0]  fold1;
    logic [3:0]  fold2;
    logic [2:0]  mod7;

    assign o_adv = !o_valid_reg || pop;
    assign s_adv = !s_valid_reg || o_adv;
    assign p_adv = !p_valid_reg || s_adv;
    assign take  = work_valid && p_adv;

    assign empty  = !o_valid_reg;
    assign result = o_result_reg;

    assign cent_prod = {18'd0, work.span} * {17'd0, DIV100_MUL};
    assign quad_prod = {18'd0, work.span[16:2]} * {15'd0, DIV100_MUL};

    assign sum_next = p_span_reg + {2'd0, p_span_reg[16:2]} + {8'd0, p_quad_reg}
                    + {11'd0, p_base_reg} - {6'd0, p_cent_reg};

    // Reduce modulo 7 by summing octal digits, since 8 is 1 modulo 7.
    assign fold1 = {3'd0, s_sum_reg[2:0]} + {3'd0, s_sum_reg[5:3]} + {3'd0, s_sum_reg[8:6]}
                 + {3'd0, s_sum_reg[11:9]} + {3'd0, s_sum_reg[14:12]}
                 + {4'd0, s_sum_reg[16:15]};
    assign fold2 = {1'b0, fold1[2:0]} + {1'b0, fold1[5:3]};
    assign mod7  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_adv)
            begin
                p_valid_reg <= work_valid;
            end
            if (s_adv)
            begin
                s_valid_reg <= p_valid_reg;
            end
            if (o_adv)
            begin
                o_valid_reg <= s_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p_status_reg <= work.status;
            p_span_reg   <= work.span;
            p_base_reg   <= work.base;
            p_cent_reg   <= cent_prod[34:DIV100_SHIFT];
            p_quad_reg   <= quad_prod[32:DIV100_SHIFT];
        end
        if (s_adv && p_valid_reg)
        begin
            s_status_reg <= p_status_reg;
            s_sum_reg    <= sum_next;
        end
        if (o_adv && s_valid_reg)
        begin
            o_result_reg.status  <= s_status_reg;
            o_result_reg.weekday <= (s_status_reg == STATUS_OK) ? mod7 : 3'd0;
        end
    end

endmodule
